// ===== design/ssnr_pkg.sv =====
// Shared types, constants and lookup functions of the seven-segment rectangle generator.
// No dependencies; compile this file first.
package ssnr_pkg;

  // Default number of decimal digits kept for display
  localparam int unsigned MAX_DIGITS_DEF = 8;

  // Field widths
  localparam int unsigned POS_W   = 16;
  localparam int unsigned NUM_W   = 32;
  localparam int unsigned COLOR_W = 16;
  localparam int unsigned COORD_W = 10;
  localparam int unsigned SIZE_W  = 11;
  localparam int unsigned GEOM_W  = 8;

  // Enough BCD digits for a 32-bit magnitude
  localparam int unsigned BCD_DIGITS = 10;

  // Screen limits
  localparam logic [SIZE_W-1:0] SCREEN_MAX    = 11'd1024;
  localparam logic [SIZE_W-1:0] WIDTH_RESET   = 11'd320;
  localparam logic [SIZE_W-1:0] HEIGHT_RESET  = 11'd240;

  // Box and glyph geometry
  localparam logic [GEOM_W-1:0] BOX_W         = 8'd150;
  localparam logic [GEOM_W-1:0] BOX_H         = 8'd50;
  localparam logic [GEOM_W-1:0] MINUS_W       = 8'd16;
  localparam logic [GEOM_W-1:0] MINUS_H       = 8'd4;
  localparam logic [POS_W-1:0]  MINUS_DY      = 16'd18;
  localparam logic [POS_W-1:0]  MINUS_SHIFT   = 16'd22;
  localparam logic [POS_W-1:0]  DIGIT_PITCH   = 16'd32;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_WIDTH  = 1'd0,
    CFG_SCREEN_HEIGHT = 1'd1
  } cfg_idx_e;

  // Segment codes in drawing order
  localparam logic [2:0] SEG_LAST = 3'd6;

  // One clipped rectangle
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [SIZE_W-1:0]  w;
    logic [SIZE_W-1:0]  h;
    logic [COLOR_W-1:0] color;
  } rect_t;

  // Placement of one segment inside its cell
  typedef struct packed {
    logic [GEOM_W-1:0] dx;
    logic [GEOM_W-1:0] dy;
    logic [GEOM_W-1:0] w;
    logic [GEOM_W-1:0] h;
  } seg_geom_t;

  // Lit segments of a decimal digit, bit 0 is the top bar
  function automatic logic [6:0] seg_map(input logic [3:0] digit);
    logic [6:0] s;
    case (digit)
      4'd0: s = 7'h3F;
      4'd1: s = 7'h06;
      4'd2: s = 7'h5B;
      4'd3: s = 7'h4F;
      4'd4: s = 7'h66;
      4'd5: s = 7'h6D;
      4'd6: s = 7'h7D;
      4'd7: s = 7'h07;
      4'd8: s = 7'h7F;
      4'd9: s = 7'h6F;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

  // Top, upper right, lower right, bottom, lower left, upper left, middle
  function automatic seg_geom_t seg_geom(input logic [2:0] seg);
    seg_geom_t g;
    case (seg)
      3'd0: g = '{dx: 8'd4,  dy: 8'd0,  w: 8'd16, h: 8'd4};
      3'd1: g = '{dx: 8'd20, dy: 8'd4,  w: 8'd4,  h: 8'd16};
      3'd2: g = '{dx: 8'd20, dy: 8'd20, w: 8'd4,  h: 8'd16};
      3'd3: g = '{dx: 8'd4,  dy: 8'd36, w: 8'd16, h: 8'd4};
      3'd4: g = '{dx: 8'd0,  dy: 8'd20, w: 8'd4,  h: 8'd16};
      3'd5: g = '{dx: 8'd0,  dy: 8'd4,  w: 8'd4,  h: 8'd16};
      3'd6: g = '{dx: 8'd4,  dy: 8'd18, w: 8'd16, h: 8'd4};
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

// ===== design/ssnr_if.sv =====
// Request and rectangle channel interfaces with valid/ready handshake.
// Depends on ssnr_pkg for field widths.
interface ssnr_req_if import ssnr_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [POS_W-1:0]          pos_x;
  logic [POS_W-1:0]          pos_y;
  logic signed [NUM_W-1:0]   number;
  logic [COLOR_W-1:0]        fg_color;
  logic [COLOR_W-1:0]        bg_color;

  modport source (output valid, pos_x, pos_y, number, fg_color, bg_color, input ready);
  modport sink   (input valid, pos_x, pos_y, number, fg_color, bg_color, output ready);
endinterface

interface ssnr_rect_if import ssnr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [COORD_W-1:0]   rect_x;
  logic [COORD_W-1:0]   rect_y;
  logic [SIZE_W-1:0]    rect_w;
  logic [SIZE_W-1:0]    rect_h;
  logic [COLOR_W-1:0]   fill_color;
  logic                 last;

  modport source (output valid, rect_x, rect_y, rect_w, rect_h, fill_color, last,
                  input ready);
  modport sink   (input valid, rect_x, rect_y, rect_w, rect_h, fill_color, last,
                  output ready);
endinterface

// ===== design/seven_segment_number_rects_core.sv =====
// A request is taken only while idle, then its magnitude is converted to BCD
// bit-serially (one magnitude bit per cycle through the shift-add-3 register); the
// first rectangle passes the pending slot and the output register, and is held longer
// when the rectangles right after it are clipped away or the sink stalls.
// Steps: background box, minus sign when negative, seven segment steps per digit, at
// one candidate rectangle per cycle; a stalled output holds the generator.
// Reset: screen size returns to 320 x 240, the sequencer goes idle, all words dropped.
module seven_segment_number_rects_core
  import ssnr_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  ssnr_req_if.sink             req,
  ssnr_rect_if.source          rect,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [SIZE_W-1:0]    cfg_data_i
);

  localparam int unsigned DIG_W  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int unsigned CONV_W = $clog2(NUM_W);
  localparam logic [CONV_W-1:0] CONV_END = CONV_W'(NUM_W - 1);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CONV  = 6'b000010,
    ST_BG    = 6'b000100,
    ST_MINUS = 6'b001000,
    ST_DIGIT = 6'b010000,
    ST_FLUSH = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic [SIZE_W-1:0] scr_w_q, scr_h_q;
  logic [SIZE_W-1:0] eff_w, eff_h;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_w_q <= WIDTH_RESET;
      scr_h_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SCREEN_WIDTH:  scr_w_q <= cfg_data_i;
        CFG_SCREEN_HEIGHT: scr_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign eff_w = (scr_w_q > SCREEN_MAX) ? SCREEN_MAX : scr_w_q;
  assign eff_h = (scr_h_q > SCREEN_MAX) ? SCREEN_MAX : scr_h_q;

  // Request payload and working registers
  logic [POS_W-1:0]   x_q, x_d, y_q;
  logic [COLOR_W-1:0] fg_q, bg_q;
  logic               neg_q;
  logic [NUM_W-1:0]   bin_q, bin_d;
  logic [BCD_DIGITS-1:0][3:0] bcd_q, bcd_d, bcd_adj;
  logic [CONV_W-1:0]  conv_cnt_q, conv_cnt_d;
  logic [DIG_W-1:0]   dig_q, dig_d, dig_start;
  logic [2:0]         seg_q, seg_d;

  logic req_fire;
  assign req.ready = (state_q == ST_IDLE);
  assign req_fire  = req.valid && req.ready;

  // Add 3 to every BCD digit of five or more, then shift in the next magnitude bit
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      bcd_adj[i] = (bcd_q[i] >= 4'd5) ? (bcd_q[i] + 4'd3) : bcd_q[i];
    end
  end

  // Kept digits and the most significant one to draw; a nonzero digit above the
  // kept ones means every kept digit is drawn, leading zeros too
  logic [MAX_DIGITS-1:0][3:0] low_digits;
  logic [3:0]                 cur_digit;
  assign low_digits = bcd_q[MAX_DIGITS-1:0];
  assign cur_digit  = low_digits[dig_q];

  always_comb begin
    dig_start = '0;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (bcd_q[i] != 4'd0) begin
        dig_start = (i < MAX_DIGITS) ? DIG_W'(i) : DIG_W'(MAX_DIGITS - 1);
      end
    end
  end

  // Candidate rectangle of the current step
  seg_geom_t          geom;
  logic               cand_valid;
  logic [POS_W-1:0]   cand_x, cand_y;
  logic [GEOM_W-1:0]  cand_w, cand_h;
  logic [COLOR_W-1:0] cand_color;
  logic [6:0]         lit;

  assign geom = seg_geom(seg_q);
  assign lit  = seg_map(cur_digit);

  always_comb begin
    cand_valid = 1'b0;
    cand_x     = x_q;
    cand_y     = y_q;
    cand_w     = BOX_W;
    cand_h     = BOX_H;
    cand_color = bg_q;
    case (state_q)
      ST_BG: begin
        cand_valid = 1'b1;
      end
      ST_MINUS: begin
        cand_valid = 1'b1;
        cand_y     = y_q + MINUS_DY;
        cand_w     = MINUS_W;
        cand_h     = MINUS_H;
        cand_color = fg_q;
      end
      ST_DIGIT: begin
        cand_valid = lit[seg_q];
        cand_x     = x_q + POS_W'(geom.dx);
        cand_y     = y_q + POS_W'(geom.dy);
        cand_w     = geom.w;
        cand_h     = geom.h;
        cand_color = fg_q;
      end
      default: ;
    endcase
  end

  // Clip against the screen
  logic              on_screen;
  logic [POS_W:0]    x_end, y_end;
  rect_t             cand_rect;

  assign on_screen = (cand_x < POS_W'(eff_w)) && (cand_y < POS_W'(eff_h));
  assign x_end     = {1'b0, cand_x} + (POS_W+1)'(cand_w);
  assign y_end     = {1'b0, cand_y} + (POS_W+1)'(cand_h);

  always_comb begin
    cand_rect.x     = cand_x[COORD_W-1:0];
    cand_rect.y     = cand_y[COORD_W-1:0];
    cand_rect.w     = (x_end > (POS_W+1)'(eff_w)) ? (eff_w - cand_x[SIZE_W-1:0])
                                                   : SIZE_W'(cand_w);
    cand_rect.h     = (y_end > (POS_W+1)'(eff_h)) ? (eff_h - cand_y[SIZE_W-1:0])
                                                   : SIZE_W'(cand_h);
    cand_rect.color = cand_color;
  end

  // Pending word (held until the next survivor or the end tells its last flag)
  // and the output register
  rect_t pend_q, pend_d, out_q, out_d;
  logic  pend_vq, pend_vd, out_vq, out_vd, out_last_q, out_last_d;
  logic  can_push, keep, gen_step, advance, out_load;

  assign can_push = !out_vq || rect.ready;
  assign keep     = cand_valid && on_screen;
  assign gen_step = (state_q == ST_BG) || (state_q == ST_MINUS) || (state_q == ST_DIGIT);
  assign advance  = gen_step && (!keep || !pend_vq || can_push);

  always_comb begin
    state_d    = state_q;
    x_d        = x_q;
    bin_d      = bin_q;
    bcd_d      = bcd_q;
    conv_cnt_d = conv_cnt_q;
    dig_d      = dig_q;
    seg_d      = seg_q;
    pend_d     = pend_q;
    pend_vd    = pend_vq;
    out_d      = out_q;
    out_last_d = out_last_q;
    out_load   = 1'b0;

    // Move a survivor into the pending slot, pushing the older one out
    if (advance && keep) begin
      pend_d  = cand_rect;
      pend_vd = 1'b1;
      if (pend_vq) begin
        out_d      = pend_q;
        out_last_d = 1'b0;
        out_load   = 1'b1;
      end
    end

    case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          bin_d      = req.number[NUM_W-1] ? (~req.number + 1'b1) : req.number;
          bcd_d      = '0;
          conv_cnt_d = '0;
          x_d        = req.pos_x;
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        bcd_d      = {bcd_adj[BCD_DIGITS-1][2:0], bcd_adj[BCD_DIGITS-2:0], bin_q[NUM_W-1]};
        bin_d      = {bin_q[NUM_W-2:0], 1'b0};
        conv_cnt_d = conv_cnt_q + 1'b1;
        if (conv_cnt_q == CONV_END) state_d = ST_BG;
      end
      ST_BG: begin
        if (advance) begin
          dig_d   = dig_start;
          seg_d   = '0;
          state_d = neg_q ? ST_MINUS : ST_DIGIT;
        end
      end
      ST_MINUS: begin
        if (advance) begin
          x_d     = x_q + MINUS_SHIFT;
          state_d = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (advance) begin
          if (seg_q == SEG_LAST) begin
            seg_d = '0;
            x_d   = x_q + DIGIT_PITCH;
            if (dig_q == '0) state_d = ST_FLUSH;
            else             dig_d   = dig_q - 1'b1;
          end else begin
            seg_d = seg_q + 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_vq) begin
          state_d = ST_IDLE;
        end else if (can_push) begin
          out_d      = pend_q;
          out_last_d = 1'b1;
          out_load   = 1'b1;
          pend_vd    = 1'b0;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (out_load)        out_vd = 1'b1;
    else if (rect.ready) out_vd = 1'b0;
    else                 out_vd = out_vq;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      pend_vq    <= 1'b0;
      out_vq     <= 1'b0;
      conv_cnt_q <= '0;
      dig_q      <= '0;
      seg_q      <= '0;
    end else begin
      state_q    <= state_d;
      pend_vq    <= pend_vd;
      out_vq     <= out_vd;
      conv_cnt_q <= conv_cnt_d;
      dig_q      <= dig_d;
      seg_q      <= seg_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    bin_q      <= bin_d;
    bcd_q      <= bcd_d;
    pend_q     <= pend_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
    if (req_fire) begin
      y_q   <= req.pos_y;
      fg_q  <= req.fg_color;
      bg_q  <= req.bg_color;
      neg_q <= req.number[NUM_W-1];
    end
  end

  // Drive the rectangle channel
  assign rect.valid      = out_vq;
  assign rect.rect_x     = out_q.x;
  assign rect.rect_y     = out_q.y;
  assign rect.rect_w     = out_q.w;
  assign rect.rect_h     = out_q.h;
  assign rect.fill_color = out_q.color;
  assign rect.last       = out_last_q;

endmodule

// ===== tb/ssnr_rect_checker.sv =====
`timescale 1ns / 1ps
// Checker for the seven-segment rectangle generator: mirrors the screen size registers,
// predicts the clipped rectangle words of each accepted request and compares them in order.
// Depends on ssnr_pkg and the request/rectangle channel interfaces in ssnr_if.sv.
module ssnr_rect_checker
  import ssnr_pkg::*;
#(
  parameter int unsigned NUM_DIGITS = MAX_DIGITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  ssnr_req_if                  req,
  ssnr_rect_if                 rect,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [SIZE_W-1:0]    cfg_data_i,
  output int unsigned          fail_count_o,
  output int unsigned          pending_o
);

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [SIZE_W-1:0]  w;
    logic [SIZE_W-1:0]  h;
    logic [COLOR_W-1:0] color;
    logic               last;
  } rect_word_t;

  logic [SIZE_W-1:0] screen_w_q;
  logic [SIZE_W-1:0] screen_h_q;
  rect_word_t        expected_rects[$];
  rect_word_t        request_rects[$];
  int unsigned       mismatches;

  // Clip one rectangle to the screen and keep it if anything is left
  task automatic clip_and_add(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                              input int unsigned w, input int unsigned h,
                              input logic [COLOR_W-1:0] color);
    int unsigned sw;
    int unsigned sh;
    int unsigned cw;
    int unsigned ch;
    rect_word_t  r;
    sw = (screen_w_q > SCREEN_MAX) ? SCREEN_MAX : screen_w_q;
    sh = (screen_h_q > SCREEN_MAX) ? SCREEN_MAX : screen_h_q;
    if (w == 0 || h == 0) return;
    if (x >= sw || y >= sh) return;
    cw = (x + w > sw) ? sw - x : w;
    ch = (y + h > sh) ? sh - y : h;
    r.x     = x[COORD_W-1:0];
    r.y     = y[COORD_W-1:0];
    r.w     = cw[SIZE_W-1:0];
    r.h     = ch[SIZE_W-1:0];
    r.color = color;
    r.last  = 1'b0;
    request_rects.push_back(r);
  endtask

  // Lit bars of a decimal digit, bit 0 is the top bar
  function automatic logic [6:0] lit_segments(input int unsigned digit);
    case (digit)
      0: return 7'h3F;
      1: return 7'h06;
      2: return 7'h5B;
      3: return 7'h4F;
      4: return 7'h66;
      5: return 7'h6D;
      6: return 7'h7D;
      7: return 7'h07;
      8: return 7'h7F;
      9: return 7'h6F;
      default: return 7'h00;
    endcase
  endfunction

  // Emit the bars of one digit cell in drawing order
  task automatic draw_digit(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                            input int unsigned digit, input logic [COLOR_W-1:0] color);
    logic [6:0] lit;
    lit = lit_segments(digit);
    if (lit[0]) clip_and_add(x + 16'd4,  y,          16, 4,  color);
    if (lit[1]) clip_and_add(x + 16'd20, y + 16'd4,  4,  16, color);
    if (lit[2]) clip_and_add(x + 16'd20, y + 16'd20, 4,  16, color);
    if (lit[3]) clip_and_add(x + 16'd4,  y + 16'd36, 16, 4,  color);
    if (lit[4]) clip_and_add(x,          y + 16'd20, 4,  16, color);
    if (lit[5]) clip_and_add(x,          y + 16'd4,  4,  16, color);
    if (lit[6]) clip_and_add(x + 16'd4,  y + 16'd18, 16, 4,  color);
  endtask

  // Build the full rectangle list of one request and queue it
  task automatic predict_number_rects(input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
                                      input logic [NUM_W-1:0] num,
                                      input logic [COLOR_W-1:0] fg,
                                      input logic [COLOR_W-1:0] bg);
    logic [POS_W-1:0] cursor;
    logic [NUM_W-1:0] mag;
    int unsigned      digits[NUM_DIGITS];
    int               cnt;
    rect_word_t       r;
    request_rects.delete();
    clip_and_add(px, py, BOX_W, BOX_H, bg);
    cursor = px;
    if (num[NUM_W-1]) begin
      clip_and_add(px, py + MINUS_DY, MINUS_W, MINUS_H, fg);
      cursor = px + MINUS_SHIFT;
      mag = ~num + 1'b1;
    end else begin
      mag = num;
    end
    if (mag == 0) begin
      draw_digit(cursor, py, 0, fg);
    end else begin
      // keep only the lowest digits, zeros among them included
      cnt = 0;
      while (mag != 0 && cnt < NUM_DIGITS) begin
        digits[cnt] = mag % 10;
        mag = mag / 10;
        cnt++;
      end
      for (int i = cnt - 1; i >= 0; i--) begin
        draw_digit(cursor, py, digits[i], fg);
        cursor = cursor + DIGIT_PITCH;
      end
    end
    foreach (request_rects[i]) begin
      r = request_rects[i];
      r.last = (i == request_rects.size() - 1);
      expected_rects.push_back(r);
    end
  endtask

  // Track registers, compare each rectangle word, predict each request word
  always @(posedge clk_i or negedge rst_ni) begin
    rect_word_t got;
    rect_word_t want;
    if (!rst_ni) begin
      screen_w_q <= WIDTH_RESET;
      screen_h_q <= HEIGHT_RESET;
      expected_rects.delete();
      mismatches = 0;
      pending_o <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_SCREEN_WIDTH) screen_w_q <= cfg_data_i;
        else screen_h_q <= cfg_data_i;
      end
      if (rect.valid && rect.ready) begin
        got.x     = rect.rect_x;
        got.y     = rect.rect_y;
        got.w     = rect.rect_w;
        got.h     = rect.rect_h;
        got.color = rect.fill_color;
        got.last  = rect.last;
        if (expected_rects.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected rect word, expected none, actual x=%0d y=%0d w=%0d h=%0d",
                   $time, got.x, got.y, got.w, got.h, " color=%04h last=%0b",
                   got.color, got.last);
        end else begin
          want = expected_rects.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.w !== want.w ||
              got.h !== want.h || got.color !== want.color || got.last !== want.last) begin
            mismatches++;
            $display("%0t: rect mismatch, expected x=%0d y=%0d w=%0d h=%0d color=%04h last=%0b",
                     $time, want.x, want.y, want.w, want.h, want.color, want.last);
            $display("%0t: rect mismatch, actual   x=%0d y=%0d w=%0d h=%0d color=%04h last=%0b",
                     $time, got.x, got.y, got.w, got.h, got.color, got.last);
          end
        end
      end
      if (req.valid && req.ready) begin
        predict_number_rects(req.pos_x, req.pos_y, req.number, req.fg_color, req.bg_color);
      end
      pending_o <= expected_rects.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

// ===== tb/seven_segment_number_rects_core_test.sv =====
`timescale 1ns / 1ps
// Top of the seven-segment rectangle generator test: clock, reset, request stimulus,
// rectangle sink with random stalls, screen register writes, watchdog and verdict.
// Depends on ssnr_pkg, ssnr_if.sv, the block itself and ssnr_rect_checker.
module seven_segment_number_rects_core_test;
  import ssnr_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 200;
  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned IDLE_LIMIT    = 5000;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we;
  cfg_idx_e          cfg_idx;
  logic [SIZE_W-1:0] cfg_data;
  int unsigned       fail_count;
  int unsigned       rects_pending;
  bit                long_hold_req;
  bit                rx_steady;
  int unsigned       cur_w;
  int unsigned       cur_h;

  ssnr_req_if  req_ch ();
  ssnr_rect_if rect_ch ();

  seven_segment_number_rects_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req        (req_ch),
    .rect       (rect_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  ssnr_rect_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req          (req_ch),
    .rect         (rect_ch),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (rects_pending)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Mostly short gaps, now and then a long one
  function automatic int unsigned idle_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 150);
    return $urandom_range(0, 3);
  endfunction

  // Position mostly near the visible area, some near the wrap point, some anywhere
  function automatic logic [POS_W-1:0] rand_pos(input int unsigned span);
    int unsigned lim;
    lim = (span > SCREEN_MAX) ? SCREEN_MAX : span;
    case ($urandom_range(0, 9))
      7:       return 16'hFFFF - POS_W'($urandom_range(0, 200));
      8, 9:    return POS_W'($urandom);
      default: return POS_W'($urandom_range(0, lim + 40));
    endcase
  endfunction

  // Value with a random digit count, sign and occasional extremes
  function automatic logic [NUM_W-1:0] rand_number();
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned r;
    int unsigned     k;
    logic [NUM_W-1:0] v;
    case ($urandom_range(0, 7))
      0: v = $urandom_range(0, 9);
      1: v = $urandom;
      2: begin
        case ($urandom_range(0, 3))
          0:       v = 32'h8000_0000;
          1:       v = 32'h7FFF_FFFF;
          2:       v = 32'hFFFF_FFFF;
          default: v = 32'h0;
        endcase
      end
      default: begin
        k = $urandom_range(1, 10);
        lo = 1;
        repeat (k - 1) lo = lo * 10;
        hi = lo * 10 - 1;
        if (hi > 64'h7FFF_FFFF) hi = 64'h7FFF_FFFF;
        r = {$urandom, $urandom};
        v = NUM_W'(lo + r % (hi - lo + 1));
        if ($urandom_range(0, 1) == 1) v = -v;
      end
    endcase
    return v;
  endfunction

  // Offer one request word, hold it until taken, then idle for the gap
  task automatic send_request(input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
                              input logic [NUM_W-1:0] num, input logic [COLOR_W-1:0] fg,
                              input logic [COLOR_W-1:0] bg, input int unsigned gap);
    req_ch.valid    <= 1'b1;
    req_ch.pos_x    <= px;
    req_ch.pos_y    <= py;
    req_ch.number   <= num;
    req_ch.fg_color <= fg;
    req_ch.bg_color <= bg;
    do @(posedge clk_i); while (!req_ch.ready);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_random(input int unsigned gap);
    send_request(rand_pos(cur_w), rand_pos(cur_h), rand_number(),
                 COLOR_W'($urandom), COLOR_W'($urandom), gap);
  endtask

  // Drop valid, wait for every expected word, then let the block settle
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk_i); while (rects_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_screen(input int unsigned w, input int unsigned h);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_SCREEN_WIDTH;
    cfg_data <= w[SIZE_W-1:0];
    @(posedge clk_i);
    cfg_idx  <= CFG_SCREEN_HEIGHT;
    cfg_data <= h[SIZE_W-1:0];
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    cur_w = w;
    cur_h = h;
  endtask

  task automatic run_random(input int unsigned n, input bit steady);
    rx_steady = steady;
    repeat (n) send_random(steady ? 0 : idle_len());
    wait_drained();
  endtask

  // Receiver: random ready stretches, steady ready, or a long hold-off on request
  initial begin : rect_sink
    bit          level;
    int unsigned left;
    rect_ch.ready = 1'b0;
    level = 1'b1;
    left = 0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        rect_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        long_hold_req = 1'b0;
      end else if (rx_steady) begin
        rect_ch.ready <= 1'b1;
      end else begin
        if (left == 0) begin
          level = ($urandom_range(0, 99) < 65);
          left = idle_len() + 1;
        end
        left--;
        rect_ch.ready <= level;
      end
    end
  end

  // End the run when nothing moves for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((req_ch.valid && req_ch.ready) || (rect_ch.valid && rect_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    rst_ni          = 1'b0;
    req_ch.valid    = 1'b0;
    req_ch.pos_x    = '0;
    req_ch.pos_y    = '0;
    req_ch.number   = '0;
    req_ch.fg_color = '0;
    req_ch.bg_color = '0;
    cfg_we          = 1'b0;
    cfg_idx         = CFG_SCREEN_WIDTH;
    cfg_data        = '0;
    long_hold_req   = 1'b0;
    rx_steady       = 1'b0;
    cur_w           = WIDTH_RESET;
    cur_h           = HEIGHT_RESET;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed words on the reset screen size
    send_request(16'd10,    16'd10,    32'd0,           16'hFFFF, 16'h0000, idle_len());
    send_request(16'd10,    16'd60,    32'd8,           16'h1234, 16'hFEDC, idle_len());
    send_request(16'd0,     16'd0,     32'd1234567890,  16'hF800, 16'h07E0, idle_len());
    send_request(16'd0,     16'd0,     32'd123456789,   16'h001F, 16'h0000, idle_len());
    send_request(16'd0,     16'd100,   -32'sd1,         16'hFFFF, 16'hFFFF, idle_len());
    send_request(16'd0,     16'd0,     32'h7FFF_FFFF,   16'h0000, 16'hFFFF, idle_len());
    send_request(16'd0,     16'd120,   32'h8000_0000,   16'hAAAA, 16'h5555, idle_len());
    send_request(16'd5,     16'd5,     32'd100000000,   16'h5555, 16'hAAAA, idle_len());
    send_request(16'd5,     16'd5,     32'd10203040,    16'h0F0F, 16'hF0F0, idle_len());
    send_request(16'd0,     16'd0,     32'd98765,       16'h3333, 16'hCCCC, idle_len());
    send_request(16'd300,   16'd200,   32'd88888888,    16'hFFFF, 16'h0001, idle_len());
    send_request(16'd319,   16'd239,   -32'sd8,         16'h8000, 16'h0001, idle_len());
    // entirely off screen: no words at all
    send_request(16'd320,   16'd0,     32'd5,           16'h1111, 16'h2222, idle_len());
    send_request(16'd0,     16'd240,   32'd5,           16'h1111, 16'h2222, idle_len());
    // coordinate wrap on x, on y, and through the sign shift
    send_request(16'hFFFF,  16'd0,     32'd1,           16'h4444, 16'h8888, idle_len());
    send_request(16'd0,     16'hFFFE,  32'd7,           16'h7777, 16'h9999, idle_len());
    send_request(16'hFFFA,  16'd10,    -32'sd4,         16'hBBBB, 16'hDDDD, idle_len());
    send_request(16'hFFFF,  16'hFFFF,  32'h8000_0000,   16'hFFFF, 16'hFFFF, idle_len());
    send_request(16'd200,   16'd100,   32'd6,           16'h0000, 16'hFFFF, idle_len());
    send_request(16'd100,   16'd30,    -32'sd90817263,  16'hE0E0, 16'h0707, idle_len());
    run_random(40, 1'b0);

    // Largest legal screen, no idling on either side
    write_screen(1024, 1024);
    run_random(40, 1'b1);

    // Oversized registers act as the largest screen
    write_screen(2047, 2047);
    run_random(40, 1'b0);

    write_screen(1, 1);
    run_random(30, 1'b0);

    // Zero width or height drops everything
    write_screen(0, 240);
    run_random(15, 1'b0);
    write_screen(320, 0);
    run_random(10, 1'b0);

    // Random screen, with the sink held off while requests keep coming
    write_screen($urandom_range(1, 1024), $urandom_range(1, 1024));
    rx_steady = 1'b0;
    long_hold_req = 1'b1;
    repeat (8) send_random(0);
    run_random(40, 1'b0);

    write_screen(640, 480);
    long_hold_req = 1'b1;
    repeat (8) send_random(0);
    run_random(60, 1'b0);

    // Screen exactly the size of the clearing box
    write_screen(150, 50);
    run_random(60, 1'b0);

    if (fail_count == 0 && rects_pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== seven_segment_number_rects_core.f =====
design/ssnr_pkg.sv
design/ssnr_if.sv
design/seven_segment_number_rects_core.sv
tb/ssnr_rect_checker.sv
tb/seven_segment_number_rects_core_test.sv
